// File: rtl/core/dq8_pkg.sv
// Shared types and constants for the eight-entry byte deque.
// Used by dq8_ctrl and double_ended_queue_8; no dependencies.
package dq8_pkg;

  localparam int unsigned DQ8_DEPTH  = 8;
  localparam int unsigned DQ8_DATA_W = 8;
  localparam int unsigned DQ8_CMD_W  = 3;
  localparam int unsigned DQ8_STAT_W = 2;
  localparam int unsigned DQ8_FILL_W = 4;

  typedef enum logic [DQ8_CMD_W-1:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_CLEAR      = 3'd4
  } dq8_cmd_e;

  typedef enum logic [DQ8_STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } dq8_status_e;

  typedef enum logic {
    DQ_IDLE = 1'b0,
    DQ_RESP = 1'b1
  } dq8_state_e;

  typedef struct packed {
    logic [DQ8_CMD_W-1:0]  command;
    logic [DQ8_DATA_W-1:0] data_in;
  } dq8_in_t;

  typedef struct packed {
    logic [DQ8_DATA_W-1:0] data_out;
    logic [DQ8_STAT_W-1:0] status;
    logic [DQ8_FILL_W-1:0] fill_count;
    logic                  is_empty;
    logic                  is_full;
  } dq8_out_t;

  // Result of one command, handed from the controller to the output stage.
  typedef struct packed {
    logic                  valid;
    logic                  pop_ok;
    logic [DQ8_STAT_W-1:0] status;
    logic [DQ8_FILL_W-1:0] fill_count;
    logic                  is_empty;
    logic                  is_full;
  } dq8_resp_t;

endpackage

// File: rtl/core/dq8_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module dq8_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/dq8_ctrl.sv
// Deque controller: head pointer, entry count and the command sequencer that
// drives the slot RAM. Depends on dq8_pkg.
module dq8_ctrl #(
  parameter int unsigned DEPTH = dq8_pkg::DQ8_DEPTH
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_fire_i,
  input  dq8_pkg::dq8_in_t              in_i,
  output logic                          mem_we_o,
  output logic [$clog2(DEPTH)-1:0]      mem_waddr_o,
  output logic [dq8_pkg::DQ8_DATA_W-1:0] mem_wdata_o,
  output logic                          mem_re_o,
  output logic [$clog2(DEPTH)-1:0]      mem_raddr_o,
  output dq8_pkg::dq8_resp_t            resp_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW:0]   DEPTH_W  = (AW + 1)'(DEPTH);
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  dq8_pkg::dq8_state_e state_q, state_d;
  logic [AW-1:0] head_q, head_d;
  logic [CW-1:0] count_q, count_d;
  logic                            pop_ok_q, pop_ok_d;
  logic [dq8_pkg::DQ8_STAT_W-1:0]  status_q, status_d;

  logic          full, empty;
  logic [AW-1:0] head_dec, head_inc, tail_idx, back_idx;
  logic [AW:0]   sum_tail, sum_back;

  assign full  = (count_q == CNT_FULL);
  assign empty = (count_q == '0);

  // Circular indexing over DEPTH slots, DEPTH need not be a power of two.
  assign head_dec = (head_q == '0) ? LAST_IDX : head_q - AW'(1);
  assign head_inc = (head_q == LAST_IDX) ? '0 : head_q + AW'(1);
  assign sum_tail = (AW + 1)'(head_q) + (AW + 1)'(count_q);
  assign sum_back = sum_tail - (AW + 1)'(1);
  assign tail_idx = (sum_tail >= DEPTH_W) ? AW'(sum_tail - DEPTH_W) : AW'(sum_tail);
  assign back_idx = (sum_back >= DEPTH_W) ? AW'(sum_back - DEPTH_W) : AW'(sum_back);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= dq8_pkg::DQ_IDLE;
      head_q   <= '0;
      count_q  <= '0;
      pop_ok_q <= 1'b0;
      status_q <= dq8_pkg::STAT_OK;
    end else begin
      state_q  <= state_d;
      head_q   <= head_d;
      count_q  <= count_d;
      pop_ok_q <= pop_ok_d;
      status_q <= status_d;
    end
  end

  always_comb begin
    state_d     = dq8_pkg::DQ_IDLE;
    head_d      = head_q;
    count_d     = count_q;
    pop_ok_d    = pop_ok_q;
    status_d    = status_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = tail_idx;
    mem_wdata_o = in_i.data_in;
    mem_re_o    = 1'b0;
    mem_raddr_o = head_q;

    if (in_fire_i) begin
      state_d  = dq8_pkg::DQ_RESP;
      pop_ok_d = 1'b0;
      status_d = dq8_pkg::STAT_OK;
      case (dq8_pkg::dq8_cmd_e'(in_i.command))
        dq8_pkg::CMD_PUSH_FRONT: begin
          if (full) begin
            status_d = dq8_pkg::STAT_FULL;
          end else begin
            mem_we_o    = 1'b1;
            mem_waddr_o = head_dec;
            head_d      = head_dec;
            count_d     = count_q + CW'(1);
          end
        end
        dq8_pkg::CMD_PUSH_BACK: begin
          if (full) begin
            status_d = dq8_pkg::STAT_FULL;
          end else begin
            mem_we_o    = 1'b1;
            mem_waddr_o = tail_idx;
            count_d     = count_q + CW'(1);
          end
        end
        dq8_pkg::CMD_POP_FRONT: begin
          if (empty) begin
            status_d = dq8_pkg::STAT_EMPTY;
          end else begin
            mem_re_o    = 1'b1;
            mem_raddr_o = head_q;
            head_d      = head_inc;
            count_d     = count_q - CW'(1);
            pop_ok_d    = 1'b1;
          end
        end
        dq8_pkg::CMD_POP_BACK: begin
          if (empty) begin
            status_d = dq8_pkg::STAT_EMPTY;
          end else begin
            mem_re_o    = 1'b1;
            mem_raddr_o = back_idx;
            count_d     = count_q - CW'(1);
            pop_ok_d    = 1'b1;
          end
        end
        dq8_pkg::CMD_CLEAR: begin
          count_d = '0;
        end
        default: begin
        end
      endcase
    end
  end

  // count_q already holds the count after the command while in DQ_RESP.
  assign resp_o.valid      = (state_q == dq8_pkg::DQ_RESP);
  assign resp_o.pop_ok     = pop_ok_q;
  assign resp_o.status     = status_q;
  assign resp_o.fill_count = dq8_pkg::DQ8_FILL_W'(count_q);
  assign resp_o.is_empty   = empty;
  assign resp_o.is_full    = full;

endmodule

// File: rtl/core/double_ended_queue_8.sv
// Byte deque of DEPTH entries (default eight) with push and pop at both ends
// and clear. Each command gives exactly one result: the popped byte (zero
// unless a pop succeeded), a status (ok, push refused because full, pop
// refused because empty), and the fill count and empty/full flags after the
// command. In the transfer cycle the controller updates the head pointer and
// entry count and issues at most one slot RAM access, and in the next cycle
// the registered RAM read data lands in the output register. A new command is
// not accepted while one is in flight, nor while a result sits in the output
// register and the consumer is stalling; an input transfer may complete while
// the output register is draining. Entries are kept in a circular buffer
// addressed from a head pointer, so push front and pop front move a pointer
// instead of shifting slots. fill_count carries the low four bits of the count.
// Depends on dq8_pkg, dq8_ctrl and dq8_ram.
module double_ended_queue_8 #(
  parameter int unsigned DEPTH = dq8_pkg::DQ8_DEPTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  dq8_pkg::dq8_in_t   in_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output dq8_pkg::dq8_out_t  out_o
);

  localparam int unsigned AW = $clog2(DEPTH);

  logic                           in_fire;
  logic                           mem_we, mem_re;
  logic [AW-1:0]                  mem_waddr, mem_raddr;
  logic [dq8_pkg::DQ8_DATA_W-1:0] mem_wdata, mem_rdata;
  dq8_pkg::dq8_resp_t             resp;

  logic              out_valid_q, out_valid_d;
  dq8_pkg::dq8_out_t out_q, out_d;

  // Hold off new commands while one is in flight, or while a finished
  // result sits in the output register and the consumer is stalling.
  assign in_stall_o = resp.valid | (out_valid_q & out_stall_i);
  assign in_fire    = in_valid_i & ~in_stall_o;

  dq8_ctrl #(
    .DEPTH(DEPTH)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_fire_i  (in_fire),
    .in_i       (in_i),
    .mem_we_o   (mem_we),
    .mem_waddr_o(mem_waddr),
    .mem_wdata_o(mem_wdata),
    .mem_re_o   (mem_re),
    .mem_raddr_o(mem_raddr),
    .resp_o     (resp)
  );

  dq8_ram #(
    .WIDTH(dq8_pkg::DQ8_DATA_W),
    .DEPTH(DEPTH)
  ) u_slots (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  // Output register: load when a result arrives, drop once transferred.
  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (resp.valid) begin
      out_valid_d         = 1'b1;
      out_d.data_out      = resp.pop_ok ? mem_rdata : '0;
      out_d.status        = resp.status;
      out_d.fill_count    = resp.fill_count;
      out_d.is_empty      = resp.is_empty;
      out_d.is_full       = resp.is_full;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

`ifndef SYNTHESIS
  // A result never lands on top of one that has not been transferred.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    resp.valid |-> !out_valid_q)
    else $error("result loaded over a pending result");

  // Every accepted command produces its result in the following cycle.
  a_resp_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (resp.valid && out_valid_d))
    else $error("accepted command produced no result");

  // A nonzero byte comes out only with an ok status (a successful pop).
  a_data_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.data_out != '0) |-> (out_q.status == dq8_pkg::STAT_OK))
    else $error("data returned with error status");

  // Empty flag and fill count agree.
  a_empty_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.is_empty) |-> (out_q.fill_count == '0 && !out_q.is_full))
    else $error("empty flag disagrees with fill count");
`endif

endmodule
